>>> rtl/bmpd_pkg.sv
// ----------------------------------------------------------------------------
// bmpd_pkg
// Shared types and constants for the BMP pixel stream decoder.
// ----------------------------------------------------------------------------
package bmpd_pkg;

   // file offsets and header values
   localparam int unsigned HEADER_BYTES  = 54;
   localparam int unsigned INFO_HDR_SIZE = 40;
   localparam int unsigned BPP_RGB       = 24;
   localparam int unsigned BPP_RGBA      = 32;
   localparam logic [15:0] MAGIC_BM      = 16'h4D42;   // "B" then "M"

   // byte position counter, saturating; wide enough to outrun any 32-bit size
   localparam int unsigned POS_W = 33;

   typedef enum logic [1:0] {
      FIN_RUN = 2'd0,
      FIN_OK  = 2'd1,
      FIN_ERR = 2'd2
   } fin_type;

   typedef enum logic [3:0] {
      ERR_NONE      = 4'd0,
      ERR_MAGIC     = 4'd1,
      ERR_OFFSET    = 4'd2,
      ERR_HDR_SIZE  = 4'd3,
      ERR_COMPRESS  = 4'd4,
      ERR_INDEXED   = 4'd5,
      ERR_DEPTH     = 4'd6,
      ERR_TOO_LARGE = 4'd7,
      ERR_OVERRUN   = 4'd8,
      ERR_LENGTH    = 4'd9,
      ERR_TRUNCATED = 4'd10
   } err_type;

   // header fields the pixel sequencer needs
   typedef struct packed {
      logic [31:0] file_size;
      logic [31:0] width;
      logic [31:0] height;
      logic [15:0] bpp;
      logic [31:0] image_bytes;
   } hdr_type;

   // one result transfer
   typedef struct packed {
      logic       has_pixel;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [11:0] column;
      logic [11:0] row;
      logic       has_alpha;
      fin_type    finish;
      err_type    error_code;
   } res_type;

endpackage

>>> rtl/bmp_pixel_stream_decoder.sv
// ----------------------------------------------------------------------------
// bmp_pixel_stream_decoder
// Streams a 24/32-bit uncompressed BMP file and emits RGB(A) pixels.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one file byte per transfer; req_end_of_file marks the last
//   byte of a file and rearms the decoder for the next one.
//   rsp_* carries one result per completed pixel, and one whenever decoding
//   finishes (ok or error). Bytes that complete nothing give no transfer.
//   Pixels come bottom row first with column and row tags; alpha is zero on
//   24-bit images and row padding is dropped.
// Timing:
//   One byte is taken every cycle while req_stall is low. A result is
//   registered on rsp_*, or in the skid entry while rsp_stall is high. All
//   per-byte work is one pass through the byte sequencer to the result register.
// Reset and flow control:
//   Synchronous reset returns to the header phase with nothing held.
//   The result register has one skid entry behind it; req_stall is high
//   exactly while that entry is full, which takes a receiver stall with a
//   result already waiting. Nothing is dropped.
// ----------------------------------------------------------------------------
module bmp_pixel_stream_decoder #(
   parameter int unsigned MAX_DIMENSION = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_has_pixel,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic [11:0] rsp_column,
   output logic [11:0] rsp_row,
   output logic        rsp_has_alpha,
   output logic [1:0]  rsp_finish,
   output logic [3:0]  rsp_error_code
);
   import bmpd_pkg::*;

   localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PIXELS,
      PH_PAD,
      PH_DONE
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [23:0]      held_ff, held_in;
   logic [1:0]       idx_ff, idx_in;
   logic [DIM_W-1:0] col_ff, col_in;
   logic [DIM_W-1:0] row_ff, row_in;
   logic [1:0]       pad_ff, pad_in;

   logic             accept;
   logic             busy;
   hdr_type          hdr;
   logic [15:0]      bpp_now;
   err_type          hdr_err;
   res_type          res;
   res_type          res_out;
   logic             res_valid;
   logic             data_end;
   logic             done_px;
   logic [DIM_W-1:0] col_inc;
   logic [DIM_W-1:0] row_inc;
   logic             is_rgb;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;
   assign is_rgb    = (hdr.bpp == 16'(BPP_RGB));

   // header fields and checks
   bmpd_hdr #(
      .MAX_DIMENSION(MAX_DIMENSION)
   ) u_hdr (
      .clock     (clock),
      .reset     (reset),
      .take      (accept && phase_ff == PH_HEADER),
      .clear     (accept && req_end_of_file),
      .pos       (pos_ff[5:0]),
      .data_byte (req_data_byte),
      .hdr       (hdr),
      .bpp_now   (bpp_now),
      .hdr_err   (hdr_err)
   );

   // per-byte step of the decoder
   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      idx_in   = idx_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      pad_in   = pad_ff;
      pos_in   = (&pos_ff) ? pos_ff : pos_ff + POS_W'(1);
      data_end = 1'b0;
      done_px  = 1'b0;
      col_inc  = col_ff + DIM_W'(1);
      row_inc  = row_ff + DIM_W'(1);

      res            = '0;
      res.finish     = FIN_RUN;
      res.error_code = ERR_NONE;
      res.has_alpha  = (bpp_now == 16'(BPP_RGBA));

      case (phase_ff)
         PH_HEADER: begin
            if (pos_ff == POS_W'(HEADER_BYTES - 1)) begin
               if (hdr_err != ERR_NONE) begin
                  res.finish     = FIN_ERR;
                  res.error_code = hdr_err;
                  phase_in       = PH_DONE;
               end else if (hdr.width == 32'd0 || hdr.height == 32'd0) begin
                  data_end = 1'b1;
               end else begin
                  phase_in = PH_PIXELS;
               end
            end
         end
         PH_PIXELS: begin
            if (idx_ff == 2'd0 &&
                (pos_ff - POS_W'(HEADER_BYTES)) > {1'b0, hdr.image_bytes}) begin
               res.finish     = FIN_ERR;
               res.error_code = ERR_OVERRUN;
               phase_in       = PH_DONE;
            end else begin
               // gather B, G, R; fourth byte is alpha
               if (idx_ff != 2'd3) begin
                  held_in[{idx_ff, 3'b000} +: 8] = req_data_byte;
                  idx_in  = idx_ff + 2'd1;
                  done_px = is_rgb && idx_ff == 2'd2;
               end else begin
                  res.alpha = req_data_byte;
                  done_px   = 1'b1;
               end
               if (done_px) begin
                  res.has_pixel = 1'b1;
                  res.blue      = held_in[7:0];
                  res.green     = held_in[15:8];
                  res.red       = held_in[23:16];
                  res.column    = 12'(col_ff);
                  res.row       = 12'(row_ff);
                  idx_in        = 2'd0;
                  col_in        = col_inc;
                  // end of row: wrap column, then padding or end of image
                  if (32'(col_inc) >= hdr.width) begin
                     col_in = '0;
                     row_in = row_inc;
                     if (is_rgb && hdr.width[1:0] != 2'd0) begin
                        pad_in   = hdr.width[1:0];
                        phase_in = PH_PAD;
                     end else if (32'(row_inc) >= hdr.height) begin
                        data_end = 1'b1;
                     end
                  end
               end
            end
         end
         PH_PAD: begin
            pad_in = pad_ff - 2'd1;
            if (pad_in == 2'd0) begin
               if (32'(row_ff) >= hdr.height) begin
                  data_end = 1'b1;
               end else begin
                  phase_in = PH_PIXELS;
               end
            end
         end
         default: begin
         end
      endcase

      // length check where pixel data ends
      if (data_end) begin
         if (pos_in == {1'b0, hdr.file_size}) begin
            res.finish = FIN_OK;
         end else begin
            res.finish     = FIN_ERR;
            res.error_code = ERR_LENGTH;
         end
         phase_in = PH_DONE;
      end

      // file ended early
      if (req_end_of_file && res.finish == FIN_RUN && phase_in != PH_DONE) begin
         res.finish     = FIN_ERR;
         res.error_code = ERR_TRUNCATED;
      end

      res_valid = res.has_pixel || res.finish != FIN_RUN;
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= '0;
         held_ff  <= '0;
         idx_ff   <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         pad_ff   <= '0;
      end else if (accept) begin
         if (req_end_of_file) begin
            phase_ff <= PH_HEADER;
            pos_ff   <= '0;
            held_ff  <= '0;
            idx_ff   <= '0;
            col_ff   <= '0;
            row_ff   <= '0;
            pad_ff   <= '0;
         end else begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            held_ff  <= held_in;
            idx_ff   <= idx_in;
            col_ff   <= col_in;
            row_ff   <= row_in;
            pad_ff   <= pad_in;
         end
      end
   end

   // result register and skid entry
   bmpd_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && res_valid),
      .res_in    (res),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .res_out   (res_out),
      .busy      (busy)
   );

   assign rsp_has_pixel  = res_out.has_pixel;
   assign rsp_red        = res_out.red;
   assign rsp_green      = res_out.green;
   assign rsp_blue       = res_out.blue;
   assign rsp_alpha      = res_out.alpha;
   assign rsp_column     = res_out.column;
   assign rsp_row        = res_out.row;
   assign rsp_has_alpha  = res_out.has_alpha;
   assign rsp_finish     = res_out.finish;
   assign rsp_error_code = res_out.error_code;

endmodule

>>> rtl/bmpd_hdr.sv
// ----------------------------------------------------------------------------
// bmpd_hdr
// Collects the little-endian header fields and checks them in priority order.
// ----------------------------------------------------------------------------
module bmpd_hdr #(
   parameter int unsigned MAX_DIMENSION = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic              clear,
   input  logic [5:0]        pos,
   input  logic [7:0]        data_byte,
   output bmpd_pkg::hdr_type hdr,
   output logic [15:0]       bpp_now,
   output bmpd_pkg::err_type hdr_err
);
   import bmpd_pkg::*;

   logic [15:0] magic_ff;
   logic [31:0] file_size_ff;
   logic [31:0] offset_ff;
   logic [31:0] info_size_ff;
   logic [31:0] width_ff;
   logic [31:0] height_ff;
   logic [15:0] bpp_ff;
   logic [31:0] compress_ff;
   logic [31:0] image_bytes_ff;
   logic [31:0] palette_ff;

   // every 32-bit field starts at an offset of 2 mod 4
   logic [1:0] lane_in;
   assign lane_in = pos[1:0] - 2'd2;

   // field capture, cleared at the end of each file
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         magic_ff       <= '0;
         file_size_ff   <= '0;
         offset_ff      <= '0;
         info_size_ff   <= '0;
         width_ff       <= '0;
         height_ff      <= '0;
         bpp_ff         <= '0;
         compress_ff    <= '0;
         image_bytes_ff <= '0;
         palette_ff     <= '0;
      end else if (take) begin
         if (pos inside {[6'd0:6'd1]}) begin
            magic_ff[{pos[0], 3'b000} +: 8] <= data_byte;
         end else if (pos inside {[6'd2:6'd5]}) begin
            file_size_ff[{lane_in, 3'b000} +: 8] <= data_byte;
         end else if (pos inside {[6'd10:6'd13]}) begin
            offset_ff[{lane_in, 3'b000} +: 8] <= data_byte;
         end else if (pos inside {[6'd14:6'd17]}) begin
            info_size_ff[{lane_in, 3'b000} +: 8] <= data_byte;
         end else if (pos inside {[6'd18:6'd21]}) begin
            width_ff[{lane_in, 3'b000} +: 8] <= data_byte;
         end else if (pos inside {[6'd22:6'd25]}) begin
            height_ff[{lane_in, 3'b000} +: 8] <= data_byte;
         end else if (pos inside {[6'd28:6'd29]}) begin
            bpp_ff[{pos[0], 3'b000} +: 8] <= data_byte;
         end else if (pos inside {[6'd30:6'd33]}) begin
            compress_ff[{lane_in, 3'b000} +: 8] <= data_byte;
         end else if (pos inside {[6'd34:6'd37]}) begin
            image_bytes_ff[{lane_in, 3'b000} +: 8] <= data_byte;
         end else if (pos inside {[6'd46:6'd49]}) begin
            palette_ff[{lane_in, 3'b000} +: 8] <= data_byte;
         end
      end
   end

   // depth including the byte taken this cycle, for the alpha flag
   always_comb begin
      bpp_now = bpp_ff;
      if (take && pos == 6'd28) begin
         bpp_now[7:0] = data_byte;
      end else if (take && pos == 6'd29) begin
         bpp_now[15:8] = data_byte;
      end
   end

   // header checks, first failure wins
   always_comb begin
      if (magic_ff != MAGIC_BM) begin
         hdr_err = ERR_MAGIC;
      end else if (offset_ff != 32'(HEADER_BYTES)) begin
         hdr_err = ERR_OFFSET;
      end else if (info_size_ff != 32'(INFO_HDR_SIZE)) begin
         hdr_err = ERR_HDR_SIZE;
      end else if (compress_ff != 32'd0) begin
         hdr_err = ERR_COMPRESS;
      end else if (palette_ff != 32'd0) begin
         hdr_err = ERR_INDEXED;
      end else if (bpp_ff != 16'(BPP_RGB) && bpp_ff != 16'(BPP_RGBA)) begin
         hdr_err = ERR_DEPTH;
      end else if (width_ff > 32'(MAX_DIMENSION) || height_ff > 32'(MAX_DIMENSION)) begin
         hdr_err = ERR_TOO_LARGE;
      end else begin
         hdr_err = ERR_NONE;
      end
   end

   assign hdr.file_size   = file_size_ff;
   assign hdr.width       = width_ff;
   assign hdr.height      = height_ff;
   assign hdr.bpp         = bpp_ff;
   assign hdr.image_bytes = image_bytes_ff;

endmodule

>>> rtl/bmpd_out.sv
// ----------------------------------------------------------------------------
// bmpd_out
// Result register with one skid entry; the input side stalls only while the
// skid entry is occupied.
// ----------------------------------------------------------------------------
module bmpd_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  bmpd_pkg::res_type res_in,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output bmpd_pkg::res_type res_out,
   output logic              busy
);
   import bmpd_pkg::*;

   logic    out_valid_ff;
   res_type out_ff;
   logic    skid_valid_ff;
   res_type skid_ff;
   logic    out_free;

   assign out_free = !out_valid_ff || !rsp_stall;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff || load;
         skid_valid_ff <= 1'b0;
      end else if (load) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : res_in;
      end else if (load) begin
         skid_ff <= res_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign res_out   = out_ff;
   assign busy      = skid_valid_ff;

endmodule
